// ===== hw/rtl/rta_pkg.sv =====
package rta_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_VERIFY   = 2'd1;

  localparam logic [2:0] STS_REFRESHED  = 3'd0;
  localparam logic [2:0] STS_ADDED      = 3'd1;
  localparam logic [2:0] STS_FULL       = 3'd2;
  localparam logic [2:0] STS_ADDR_LIMIT = 3'd3;
  localparam logic [2:0] STS_VERIFIED   = 3'd4;
  localparam logic [2:0] STS_REJECTED   = 3'd5;
  localparam logic [2:0] STS_TICK       = 3'd6;
  localparam logic [2:0] STS_CHALLENGE  = 3'd7;

  localparam logic [1:0] CFG_VERIFIED_TIMEOUT   = 2'd0;
  localparam logic [1:0] CFG_UNVERIFIED_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_PER_ADDRESS_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_CHALLENGE_INTERVAL = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] age;
    logic        verified;
    logic        pinged;
    logic [31:0] key;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [15:0] verified_timeout;
    logic [15:0] unverified_timeout;
    logic [10:0] per_address_limit;
    logic [15:0] challenge_interval;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] ip_address;
    logic [15:0] port_number;
    logic [31:0] key_value;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot_index;
    logic [31:0] challenge_ip;
    logic [15:0] challenge_port;
    logic [31:0] challenge_key;
    logic [10:0] removed_count;
    logic [10:0] entry_count;
  } result_t;

endpackage

// ===== hw/rtl/rta_in_if.sv =====
interface rta_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] ip_address;
  logic [15:0] port_number;
  logic [31:0] key_value;

  modport source (output valid, operation, ip_address, port_number, key_value, input ready);
  modport sink (input valid, operation, ip_address, port_number, key_value, output ready);
endinterface

// ===== hw/rtl/rta_out_if.sv =====
interface rta_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  slot_index;
  logic [31:0] challenge_ip;
  logic [15:0] challenge_port;
  logic [31:0] challenge_key;
  logic [10:0] removed_count;
  logic [10:0] entry_count;

  modport source (output valid, status, slot_index, challenge_ip, challenge_port,
                  challenge_key, removed_count, entry_count, input ready);
  modport sink (input valid, status, slot_index, challenge_ip, challenge_port,
                challenge_key, removed_count, entry_count, output ready);
endinterface

// ===== hw/rtl/rta_ram.sv =====
module rta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/rta_engine.sv =====
module rta_engine import rta_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    idle_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_take_i
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic             rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  entry_t           hit_q, hit_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [CNT_W-1:0] vcount_q, vcount_d;
  logic [CNT_W-1:0] removed_q, removed_d;
  logic             hi_found_q, hi_found_d;
  logic [IDX_W-1:0] hi_idx_q, hi_idx_d;
  entry_t           hi_q, hi_d;
  logic             lo_found_q, lo_found_d;
  logic [IDX_W-1:0] lo_idx_q, lo_idx_d;
  entry_t           lo_q, lo_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [15:0]      tick_q, tick_d;
  result_t          res_q, res_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  rta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic             is_tick;
  entry_t           aged;
  logic [15:0]      age_limit;
  logic             expire;
  logic             limit_hit;
  logic             chosen_ok;
  logic [IDX_W-1:0] chosen_idx;
  entry_t           chosen;
  logic [15:0]      tick_next;
  logic [15:0]      interval;

  assign is_tick = (item_q.operation != OP_REGISTER) && (item_q.operation != OP_VERIFY);
  assign limit_hit = 32'(vcount_q) >= 32'(cfg_i.per_address_limit);
  assign interval = (cfg_i.challenge_interval == 16'd0) ? 16'd1 : cfg_i.challenge_interval;

  always_comb begin
    aged = ram_rdata;
    if (ram_rdata.age != 16'hFFFF) begin
      aged.age = ram_rdata.age + 16'd1;
    end
    age_limit = ram_rdata.verified ? cfg_i.verified_timeout : cfg_i.unverified_timeout;
    expire = aged.age > age_limit;
    aged.valid = ram_rdata.valid && !expire;
  end

  always_comb begin
    chosen_ok  = hi_found_q || lo_found_q;
    chosen_idx = hi_found_q ? hi_idx_q : lo_idx_q;
    chosen     = hi_found_q ? hi_q : lo_q;
    tick_next  = tick_q + 16'd1;
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    scan_cnt_d   = scan_cnt_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    vcount_d     = vcount_q;
    removed_d    = removed_q;
    hi_found_d   = hi_found_q;
    hi_idx_d     = hi_idx_q;
    hi_d         = hi_q;
    lo_found_d   = lo_found_q;
    lo_idx_d     = lo_idx_q;
    lo_d         = lo_q;
    occ_d        = occ_q;
    ptr_d        = ptr_q;
    tick_d       = tick_q;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = rd_idx_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = scan_cnt_q[IDX_W-1:0];

    case (state_q)
      S_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = scan_cnt_q[IDX_W-1:0];
        ram_wdata  = '0;
        scan_cnt_d = scan_cnt_q + CNT_W'(1);
        if (scan_cnt_q == CNT_W'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid_i) begin
          item_d       = item_i;
          scan_cnt_d   = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          vcount_d     = '0;
          removed_d    = '0;
          hi_found_d   = 1'b0;
          lo_found_d   = 1'b0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt_q < CNT_W'(TABLE_DEPTH)) begin
          ram_re     = 1'b1;
          rd_pend_d  = 1'b1;
          rd_idx_d   = scan_cnt_q[IDX_W-1:0];
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
        end
        // Data for the read issued last cycle arrives now; the write-back goes to
        // that older slot, so it never collides with the read in flight.
        if (rd_pend_q) begin
          if (!is_tick) begin
            if (ram_rdata.valid && ram_rdata.ip == item_q.ip_address &&
                ram_rdata.port == item_q.port_number && !found_q) begin
              found_d   = 1'b1;
              hit_idx_d = rd_idx_q;
              hit_d     = ram_rdata;
            end
            if (!ram_rdata.valid && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = rd_idx_q;
            end
            if (ram_rdata.valid && ram_rdata.verified &&
                ram_rdata.ip == item_q.ip_address) begin
              vcount_d = vcount_q + CNT_W'(1);
            end
          end else if (ram_rdata.valid) begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx_q;
            ram_wdata = aged;
            if (expire) begin
              removed_d = removed_q + CNT_W'(1);
            end else begin
              if (!lo_found_q) begin
                lo_found_d = 1'b1;
                lo_idx_d   = rd_idx_q;
                lo_d       = aged;
              end
              if (!hi_found_q && rd_idx_q >= ptr_q) begin
                hi_found_d = 1'b1;
                hi_idx_d   = rd_idx_q;
                hi_d       = aged;
              end
            end
          end
          if (rd_idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        res_d = '0;
        state_d = S_DONE;
        if (item_q.operation == OP_REGISTER) begin
          if (found_q) begin
            ram_we             = 1'b1;
            ram_waddr          = hit_idx_q;
            ram_wdata          = hit_q;
            ram_wdata.age      = '0;
            ram_wdata.pinged   = 1'b0;
            res_d.status       = STS_REFRESHED;
            res_d.slot_index   = 10'(hit_idx_q);
          end else if (!free_found_q) begin
            res_d.status = STS_FULL;
          end else if (limit_hit) begin
            res_d.status = STS_ADDR_LIMIT;
          end else begin
            ram_we           = 1'b1;
            ram_waddr        = free_idx_q;
            ram_wdata        = '0;
            ram_wdata.valid  = 1'b1;
            ram_wdata.ip     = item_q.ip_address;
            ram_wdata.port   = item_q.port_number;
            occ_d            = occ_q + CNT_W'(1);
            res_d.status     = STS_ADDED;
            res_d.slot_index = 10'(free_idx_q);
          end
        end else if (item_q.operation == OP_VERIFY) begin
          res_d.status = STS_REJECTED;
          if (found_q) begin
            res_d.slot_index = 10'(hit_idx_q);
            if (hit_q.key != 32'd0 && hit_q.key == item_q.key_value && !limit_hit) begin
              ram_we             = 1'b1;
              ram_waddr          = hit_idx_q;
              ram_wdata          = hit_q;
              ram_wdata.verified = 1'b1;
              ram_wdata.age      = '0;
              res_d.status       = STS_VERIFIED;
            end
          end
        end else begin
          occ_d        = occ_q - removed_q;
          res_d.status = STS_TICK;
          res_d.removed_count = 11'(removed_q);
          if (tick_q == 16'd0 && chosen_ok) begin
            res_d.slot_index = 10'(chosen_idx);
            ptr_d = (chosen_idx == IDX_W'(TABLE_DEPTH - 1)) ? '0 : chosen_idx + IDX_W'(1);
            if (!(chosen.pinged && !chosen.verified)) begin
              ram_we               = 1'b1;
              ram_waddr            = chosen_idx;
              ram_wdata            = chosen;
              ram_wdata.key        = item_q.key_value;
              ram_wdata.pinged     = 1'b1;
              res_d.status         = STS_CHALLENGE;
              res_d.challenge_ip   = chosen.ip;
              res_d.challenge_port = chosen.port;
              res_d.challenge_key  = item_q.key_value;
            end
          end
          tick_d = (tick_next >= interval) ? 16'd0 : tick_next;
        end
        res_d.entry_count = 11'(occ_d);
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      scan_cnt_q <= '0;
      rd_pend_q  <= 1'b0;
      occ_q      <= '0;
      ptr_q      <= '0;
      tick_q     <= '0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      rd_pend_q  <= rd_pend_d;
      occ_q      <= occ_d;
      ptr_q      <= ptr_d;
      tick_q     <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    rd_idx_q     <= rd_idx_d;
    found_q      <= found_d;
    hit_idx_q    <= hit_idx_d;
    hit_q        <= hit_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    vcount_q     <= vcount_d;
    removed_q    <= removed_d;
    hi_found_q   <= hi_found_d;
    hi_idx_q     <= hi_idx_d;
    hi_q         <= hi_d;
    lo_found_q   <= lo_found_d;
    lo_idx_q     <= lo_idx_d;
    lo_q         <= lo_d;
    res_q        <= res_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

// ===== hw/rtl/registration_table_with_aging.sv =====
// Table of registered endpoints (IPv4 address and port) with aging and
// round-robin challenge issue.
// Items come in on in_i and one result per item leaves on out_o; both
// channels transfer on a clock edge with valid and ready high.
// Each item sweeps the whole table memory once, one entry per cycle through
// the single read and single write port, and then hands its result to the
// output register. A new item is taken only after that hand-over.
// The result waits in an output register, so the next item is taken while
// a stalled receiver still holds off the previous result; the block then
// stops after that item's sweep until the output register is free.
// After reset the block clears every entry of the table memory and holds
// in_i.ready low meanwhile. Configuration writes are taken at any time; they
// are registered and take effect from then on, also on an item in progress,
// and belong only in periods when no item is in progress.
module registration_table_with_aging import rta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rta_in_if.sink      in_i,
  rta_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  cfg_t    cfg_q, cfg_d;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  logic    eng_idle, eng_res_valid, eng_take;
  result_t eng_res;
  item_t   item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VERIFIED_TIMEOUT:   cfg_d.verified_timeout   = cfg_wdata_i;
        CFG_UNVERIFIED_TIMEOUT: cfg_d.unverified_timeout = cfg_wdata_i;
        CFG_PER_ADDRESS_LIMIT:  cfg_d.per_address_limit  = cfg_wdata_i[10:0];
        CFG_CHALLENGE_INTERVAL: cfg_d.challenge_interval = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  assign item.operation   = in_i.operation;
  assign item.ip_address  = in_i.ip_address;
  assign item.port_number = in_i.port_number;
  assign item.key_value   = in_i.key_value;
  assign in_i.ready       = eng_idle;

  rta_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (in_i.valid),
    .item_i       (item),
    .idle_o       (eng_idle),
    .res_valid_o  (eng_res_valid),
    .res_o        (eng_res),
    .res_take_i   (eng_take)
  );

  assign eng_take = eng_res_valid && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (eng_take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.verified_timeout   <= 16'd5000;
      cfg_q.unverified_timeout <= 16'd1000;
      cfg_q.per_address_limit  <= 11'd64;
      cfg_q.challenge_interval <= 16'd100;
      out_valid_q              <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_take) begin
      out_q <= eng_res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_q.status;
  assign out_o.slot_index     = out_q.slot_index;
  assign out_o.challenge_ip   = out_q.challenge_ip;
  assign out_o.challenge_port = out_q.challenge_port;
  assign out_o.challenge_key  = out_q.challenge_key;
  assign out_o.removed_count  = out_q.removed_count;
  assign out_o.entry_count    = out_q.entry_count;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item taken while a sweep is in progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(out_q.entry_count) <= 32'(TABLE_DEPTH)))
    else $error("occupied count exceeds table depth");

  a_no_challenge_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STS_CHALLENGE) |->
    (out_q.challenge_ip == 32'd0 && out_q.challenge_key == 32'd0 &&
     out_q.challenge_port == 16'd0))
    else $error("challenge fields set without a challenge");

  a_removed_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STS_TICK && out_q.status != STS_CHALLENGE) |->
    (out_q.removed_count == 11'd0))
    else $error("removed count on a non-tick result");

endmodule
